FILE: hdl/msta_pkg.sv
// ============================================================================
// msta_pkg: shared definitions for the mixed-radix time accumulator
// Widths, operation codes and the divider result bundle.
// ============================================================================
package msta_pkg;

  // Field widths fixed by the interface.
  localparam int HOURS_W = 32;
  localparam int RADIX_W = 16;
  localparam int DELTA_W = 32;

  // Seconds and minutes sums before normalization fit in 35 signed bits.
  localparam int ACC_W = 35;
  // Magnitude seen by the divider (one's complement of a negative value).
  localparam int MAG_W = ACC_W - 1;
  localparam int CNT_W = $clog2(MAG_W);
  // Hours part plus carry plus held hours fit in 37 signed bits.
  localparam int PART_W = 37;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 16'd60;

  localparam logic signed [HOURS_W-1:0] HOURS_MAX = {1'b0, {(HOURS_W-1){1'b1}}};
  localparam logic signed [HOURS_W-1:0] HOURS_MIN = {1'b1, {(HOURS_W-1){1'b0}}};

  // Operation codes.
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ADD  = 2'd1;
  localparam logic [1:0] FUNC_SUB  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_MPH = 1'b0;
  localparam logic CFG_SPM = 1'b1;

  // Result of the shared floor divider.
  typedef struct packed {
    logic                      done;
    logic signed [ACC_W-1:0]   quo;
    logic        [RADIX_W-1:0] rem;
  } div_res_t;

endpackage

FILE: hdl/msta_div.sv
// ============================================================================
// msta_div: iterative signed floor divider
// Radix-2 restoring division of a signed value by a positive radix, one
// quotient bit per cycle, with floor rounding for negative dividends.
// ============================================================================
module msta_div
  import msta_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [ACC_W-1:0]   dividend,
  input  logic        [RADIX_W-1:0] divisor,
  output div_res_t                  res
);

  logic                 busy;
  logic                 done;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;
  logic [RADIX_W-1:0]   dvsr;
  logic [RADIX_W-1:0]   rem;
  logic [MAG_W-1:0]     qsh;

  logic [RADIX_W:0]     rem_sh;
  logic [RADIX_W:0]     diff;
  logic                 fits;
  logic [ACC_W-1:0]     mag;

  // A negative dividend is divided as its one's complement: floor(a/d) is
  // then the complement of the quotient and the remainder is d-1-R.
  assign mag    = dividend[ACC_W-1] ? ~dividend : dividend;
  assign rem_sh = {rem, qsh[MAG_W-1]};
  assign diff   = rem_sh - {1'b0, dvsr};
  assign fits   = rem_sh >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[ACC_W-1];
      dvsr <= divisor;
      rem  <= '0;
      qsh  <= mag[MAG_W-1:0];
    end else if (busy) begin
      rem <= fits ? diff[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
      qsh <= {qsh[MAG_W-2:0], fits};
    end
  end

  assign res.done = done;
  assign res.quo  = neg ? ~{1'b0, qsh} : {1'b0, qsh};
  assign res.rem  = neg ? (dvsr - 16'd1 - rem) : rem;

endmodule

FILE: hdl/mixed_radix_time_accumulator.sv
// ============================================================================
// mixed_radix_time_accumulator: hours/minutes/seconds accumulator
// Loads, adds or subtracts a time delta and normalizes it by floor division.
// ============================================================================
// Each accepted item loads the held time, adds its delta to it, or subtracts
// its delta from it, and then normalizes: seconds are floor-divided by the
// seconds-per-minute radix and the quotient carries into minutes, which are
// floor-divided by the minutes-per-hour radix with the quotient carrying into
// hours. Minutes and seconds always end in 0 to radix-1, also for negative
// or unnormalized deltas; a radix of zero acts as one. Hours saturate at the
// signed 32-bit limits and hours_overflow flags the step that clamped them.
// Operation code 3 leaves the time as it is and reports it. Both divisions
// run one after the other on a single radix-2 divider that retires one
// quotient bit per cycle over a 34-bit magnitude; an item with code 3
// skips the divider. The result is registered at the output. One result
// item is returned per input item; the block accepts a new item while a
// finished result still waits at the output register, but does not finish
// it until that result is taken.
// Radices go through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle (not enforced by it). Both reset to 60.
// ============================================================================
module mixed_radix_time_accumulator
  import msta_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,

  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic signed [DELTA_W-1:0]   delta_hours,
  input  logic signed [DELTA_W-1:0]   delta_minutes,
  input  logic signed [DELTA_W-1:0]   delta_seconds,

  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [HOURS_W-1:0]   out_hours,
  output logic        [RADIX_W-1:0]   out_minutes,
  output logic        [RADIX_W-1:0]   out_seconds,
  output logic                        hours_overflow,

  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic        [RADIX_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC_GO,
    S_SEC_WAIT,
    S_MIN_GO,
    S_MIN_WAIT,
    S_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RADIX_W-1:0] minutes_per_hour;
  logic [RADIX_W-1:0] seconds_per_minute;
  logic [RADIX_W-1:0] mph_eff;
  logic [RADIX_W-1:0] spm_eff;

  // Held time.
  logic signed [HOURS_W-1:0] held_hours;
  logic        [RADIX_W-1:0] held_minutes;
  logic        [RADIX_W-1:0] held_seconds;

  // Working registers for the item in flight.
  logic signed [ACC_W-1:0]   s_acc;
  logic signed [ACC_W-1:0]   m_acc;
  logic signed [PART_W-1:0]  part;
  logic signed [HOURS_W-1:0] base_h;
  logic                      hold_only;

  // Values formed at acceptance.
  logic signed [ACC_W-1:0]   ds_x;
  logic signed [ACC_W-1:0]   dm_x;
  logic signed [ACC_W-1:0]   hs_x;
  logic signed [ACC_W-1:0]   hm_x;
  logic signed [PART_W-1:0]  dh_x;
  logic signed [ACC_W-1:0]   s_in;
  logic signed [ACC_W-1:0]   m_in;
  logic signed [PART_W-1:0]  part_in;
  logic signed [HOURS_W-1:0] base_in;
  logic                      hold_in;

  // Final hours.
  logic signed [PART_W-1:0]  h_sum;
  logic signed [HOURS_W-1:0] h_sat;
  logic                      h_ovf;

  logic                      in_acc;
  logic                      out_load;
  logic                      div_start;
  logic signed [ACC_W-1:0]   div_dividend;
  logic        [RADIX_W-1:0] div_divisor;
  div_res_t                  div_res;

  assign mph_eff = (minutes_per_hour == '0) ? 16'd1 : minutes_per_hour;
  assign spm_eff = (seconds_per_minute == '0) ? 16'd1 : seconds_per_minute;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  // The finished result may only enter the output register once it is free.
  assign out_load = (state == S_FINISH) && (!out_valid || out_ready);

  always_comb begin
    ds_x    = ACC_W'(delta_seconds);
    dm_x    = ACC_W'(delta_minutes);
    dh_x    = PART_W'(delta_hours);
    hs_x    = ACC_W'({1'b0, held_seconds});
    hm_x    = ACC_W'({1'b0, held_minutes});
    s_in    = hs_x;
    m_in    = hm_x;
    part_in = '0;
    base_in = held_hours;
    hold_in = 1'b0;
    unique case (func)
      FUNC_LOAD: begin
        s_in    = ds_x;
        m_in    = dm_x;
        part_in = dh_x;
        base_in = '0;
      end
      FUNC_ADD: begin
        s_in    = hs_x + ds_x;
        m_in    = hm_x + dm_x;
        part_in = dh_x;
      end
      FUNC_SUB: begin
        s_in    = hs_x - ds_x;
        m_in    = hm_x - dm_x;
        part_in = -dh_x;
      end
      default: begin
        hold_in = 1'b1;
      end
    endcase
  end

  // The shared divider first reduces seconds, then minutes.
  assign div_start    = (state == S_SEC_GO) || (state == S_MIN_GO);
  assign div_dividend = (state == S_SEC_GO) ? s_acc : m_acc;
  assign div_divisor  = (state == S_SEC_GO) ? spm_eff : mph_eff;

  msta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  // Held hours plus the hours part, clamped to the 32-bit range.
  always_comb begin
    h_sum = PART_W'(base_h) + part;
    h_sat = h_sum[HOURS_W-1:0];
    h_ovf = 1'b0;
    if (h_sum > PART_W'(HOURS_MAX)) begin
      h_sat = HOURS_MAX;
      h_ovf = 1'b1;
    end else if (h_sum < PART_W'(HOURS_MIN)) begin
      h_sat = HOURS_MIN;
      h_ovf = 1'b1;
    end
  end

  // Configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      minutes_per_hour   <= RADIX_RESET;
      seconds_per_minute <= RADIX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MPH: minutes_per_hour   <= cfg_data;
        CFG_SPM: seconds_per_minute <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, held time and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      held_hours   <= '0;
      held_minutes <= '0;
      held_seconds <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= hold_in ? S_FINISH : S_SEC_GO;
          end
        end
        S_SEC_GO: begin
          state <= S_SEC_WAIT;
        end
        S_SEC_WAIT: begin
          if (div_res.done) begin
            held_seconds <= div_res.rem;
            state        <= S_MIN_GO;
          end
        end
        S_MIN_GO: begin
          state <= S_MIN_WAIT;
        end
        S_MIN_WAIT: begin
          if (div_res.done) begin
            held_minutes <= div_res.rem;
            state        <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (!hold_only) begin
              held_hours <= h_sat;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_acc     <= s_in;
      m_acc     <= m_in;
      part      <= part_in;
      base_h    <= base_in;
      hold_only <= hold_in;
    end else if (state == S_SEC_WAIT && div_res.done) begin
      m_acc <= m_acc + div_res.quo;
    end else if (state == S_MIN_WAIT && div_res.done) begin
      part <= part + PART_W'(div_res.quo);
    end
    if (out_load) begin
      out_hours      <= hold_only ? held_hours : h_sat;
      out_minutes    <= held_minutes;
      out_seconds    <= held_seconds;
      hours_overflow <= hold_only ? 1'b0 : h_ovf;
    end
  end

  // The divider only reports a result while the sequencer waits for one.
  assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_SEC_WAIT || state == S_MIN_WAIT))
    else $error("divider finished outside a wait state");

  // An accepted item always leaves the idle state.
  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  // A freshly computed result has normalized seconds and minutes.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && !hold_only) |=>
      (out_seconds < spm_eff) && (out_minutes < mph_eff))
    else $error("result not normalized");

  // The overflow flag only accompanies a clamped hours value.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && hours_overflow) |->
      (out_hours == HOURS_MAX || out_hours == HOURS_MIN))
    else $error("overflow flagged without saturated hours");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for mixed_radix_time_accumulator
// Drives load, add, subtract and hold items under several radix settings
// and idling patterns, predicts every normalized time, and compares each
// returned item field by field in arrival order.
// ============================================================================
module testbench;
  import msta_pkg::*;

  // The block ignores operation code 3 and reports the held time unchanged.
  localparam logic [1:0] FUNC_HOLD = 2'd3;

  // The limit leaves ample room for the slowest correct run.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_PER_PHASE = 230;
  localparam int NUM_PHASES = 8;

  typedef struct {
    logic signed [HOURS_W-1:0] hours;
    logic        [RADIX_W-1:0] minutes;
    logic        [RADIX_W-1:0] seconds;
    logic                      overflow;
  } time_result_t;

  // Keeps its own copy of the held time and of both radices, computes the
  // normalized time for every accepted item, and checks returned items
  // against those predictions in order.
  class time_scoreboard;
    logic [RADIX_W-1:0] minutes_radix;
    logic [RADIX_W-1:0] seconds_radix;
    longint             held_h;
    longint             held_m;
    longint             held_s;
    time_result_t       expected_q[$];
    int                 mismatches;
    int                 checked;

    function new();
      minutes_radix = RADIX_RESET;
      seconds_radix = RADIX_RESET;
      held_h = 0;
      held_m = 0;
      held_s = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_radix(logic idx, logic [RADIX_W-1:0] value);
      if (idx == CFG_MPH) begin
        minutes_radix = value;
      end else begin
        seconds_radix = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Floor division by a positive divisor; the remainder is never negative.
    function void floor_split(longint num, longint den, output longint quo,
                              output longint rem);
      quo = num / den;
      rem = num % den;
      if (rem < 0) begin
        rem += den;
        quo -= 1;
      end
    endfunction

    function void note_input(logic [1:0] op, logic signed [DELTA_W-1:0] dh,
                             logic signed [DELTA_W-1:0] dm,
                             logic signed [DELTA_W-1:0] ds);
      longint       base_h, m_sum, s_sum, part, carry, new_m, new_s, h, rad_m, rad_s;
      bit           clamped;
      time_result_t r;
      clamped = 1'b0;
      rad_m = (minutes_radix == 0) ? 1 : longint'(minutes_radix);
      rad_s = (seconds_radix == 0) ? 1 : longint'(seconds_radix);
      if (op != FUNC_HOLD) begin
        case (op)
          FUNC_LOAD: begin
            base_h = 0;
            m_sum = longint'(dm);
            s_sum = longint'(ds);
            part = longint'(dh);
          end
          FUNC_ADD: begin
            base_h = held_h;
            m_sum = held_m + longint'(dm);
            s_sum = held_s + longint'(ds);
            part = longint'(dh);
          end
          default: begin
            base_h = held_h;
            m_sum = held_m - longint'(dm);
            s_sum = held_s - longint'(ds);
            part = -longint'(dh);
          end
        endcase
        floor_split(s_sum, rad_s, carry, new_s);
        m_sum += carry;
        floor_split(m_sum, rad_m, carry, new_m);
        part += carry;
        // All terms stay far inside 64 bits, so a plain add is exact here.
        h = base_h + part;
        if (h > longint'(HOURS_MAX)) begin
          h = longint'(HOURS_MAX);
          clamped = 1'b1;
        end else if (h < longint'(HOURS_MIN)) begin
          h = longint'(HOURS_MIN);
          clamped = 1'b1;
        end
        held_h = h;
        held_m = new_m;
        held_s = new_s;
      end
      r.hours = held_h[HOURS_W-1:0];
      r.minutes = held_m[RADIX_W-1:0];
      r.seconds = held_s[RADIX_W-1:0];
      r.overflow = clamped;
      expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, checked, msg);
      mismatches++;
    endtask

    task check_result(logic signed [HOURS_W-1:0] hours, logic [RADIX_W-1:0] minutes,
                      logic [RADIX_W-1:0] seconds, logic overflow);
      time_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result item arrived with no item pending");
      end else begin
        want = expected_q.pop_front();
        if (hours !== want.hours) begin
          report_mismatch($sformatf("out_hours %0d, expected %0d", hours, want.hours));
        end
        if (minutes !== want.minutes) begin
          report_mismatch($sformatf("out_minutes %0d, expected %0d",
                                    minutes, want.minutes));
        end
        if (seconds !== want.seconds) begin
          report_mismatch($sformatf("out_seconds %0d, expected %0d",
                                    seconds, want.seconds));
        end
        if (overflow !== want.overflow) begin
          report_mismatch($sformatf("hours_overflow %0b, expected %0b",
                                    overflow, want.overflow));
        end
      end
      checked++;
    endtask
  endclass

  // Every input is known from time zero; reset is held high until released.
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 func = FUNC_LOAD;
  logic signed [DELTA_W-1:0]  delta_hours = '0;
  logic signed [DELTA_W-1:0]  delta_minutes = '0;
  logic signed [DELTA_W-1:0]  delta_seconds = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [HOURS_W-1:0]  out_hours;
  logic        [RADIX_W-1:0]  out_minutes;
  logic        [RADIX_W-1:0]  out_seconds;
  logic                       hours_overflow;
  logic                       cfg_we = 1'b0;
  logic                       cfg_index = CFG_MPH;
  logic        [RADIX_W-1:0]  cfg_data = '0;

  time_scoreboard sb;
  int unsigned    cycle_count = 0;
  // Idling odds in percent: the sender holds valid low, the receiver holds
  // ready low. The main process changes them between phases.
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_stall_pct = 0;

  mixed_radix_time_accumulator u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .delta_hours    (delta_hours),
    .delta_minutes  (delta_minutes),
    .delta_seconds  (delta_seconds),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hours      (out_hours),
    .out_minutes    (out_minutes),
    .out_seconds    (out_seconds),
    .hours_overflow (hours_overflow),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items still pending",
               cycle_count, sb.pending());
      $display("** mixed_radix_time_accumulator: FAILED **");
      $finish;
    end
  end

  // Receiver side. Values seen here are the ones from before this edge, so
  // a result item counts as taken exactly when both valid and ready were
  // high. Ready is then redrawn for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        sb.check_result(out_hours, out_minutes, out_seconds, hours_overflow);
      end
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Presents one item and returns at the edge that accepts it. Valid is left
  // high afterwards so that back-to-back items never see valid dropped and
  // raised in the same step; idle cycles, if drawn, lower it first.
  task automatic send_item(logic [1:0] op, logic signed [DELTA_W-1:0] dh,
                           logic signed [DELTA_W-1:0] dm,
                           logic signed [DELTA_W-1:0] ds);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    delta_hours <= dh;
    delta_minutes <= dm;
    delta_seconds <= ds;
    do begin
      @(posedge clk);
    end while (!in_ready);
    sb.note_input(op, dh, dm, ds);
  endtask

  // Ends a burst and waits until every predicted item has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Register writes happen only with the block idle. The extra edge keeps
  // the enable from being lowered and raised in one step.
  task automatic write_cfg(logic idx, logic [RADIX_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_radix(idx, value);
    @(posedge clk);
  endtask

  // One delta field. Hours are mostly small so that the held time wanders
  // rather than pinning at a limit; minutes and seconds mix full-range
  // values, values near the radix, exact multiples of it (the case where
  // negative fields must not borrow) and the 32-bit extremes.
  function automatic logic signed [DELTA_W-1:0] pick_delta(logic [RADIX_W-1:0] radix,
                                                           bit for_hours);
    int unsigned sel;
    int          r;
    int          k;
    logic signed [DELTA_W-1:0] v;
    sel = $urandom_range(99);
    r = (radix == 0) ? 1 : int'(radix);
    k = int'($urandom_range(10)) - 5;
    if (for_hours) begin
      sel = (sel < 70) ? 30 : (sel < 85) ? 0 : 95;
    end
    if (sel < 25) begin
      v = $urandom;
    end else if (sel < 50) begin
      v = int'($urandom_range(6 * r)) - 3 * r;
    end else if (sel < 70) begin
      v = k * r;
    end else if (sel < 90) begin
      v = int'($urandom_range(1 << 20)) - (1 << 19);
    end else begin
      case ($urandom_range(4))
        0: v = 0;
        1: v = 1;
        2: v = -1;
        3: v = 32'sh7fff_ffff;
        default: v = 32'sh8000_0000;
      endcase
    end
    return v;
  endfunction

  task automatic send_random();
    int unsigned           sel;
    logic [1:0]            op;
    sel = $urandom_range(99);
    if (sel < 15) begin
      op = FUNC_LOAD;
    end else if (sel < 55) begin
      op = FUNC_ADD;
    end else if (sel < 95) begin
      op = FUNC_SUB;
    end else begin
      op = FUNC_HOLD;
    end
    send_item(op, pick_delta(16'd1, 1'b1), pick_delta(sb.minutes_radix, 1'b0),
              pick_delta(sb.seconds_radix, 1'b0));
  endtask

  // Idling patterns rotate per phase: none, sender only, receiver only, and
  // both at a light rate.
  task automatic set_idling(int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
      default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
    endcase
  endtask

  initial begin
    logic [RADIX_W-1:0] mph_set[NUM_PHASES];
    logic [RADIX_W-1:0] spm_set[NUM_PHASES];
    sb = new();
    // Radix pairs per phase: both minimal, both maximal, a day-like mix, the
    // zero radix that must act as one, lopsided extremes, random, and back
    // to the reset values.
    mph_set = '{16'd1, 16'd65535, 16'd24, 16'd0, 16'd7, 16'd65535, 16'd0, 16'd60};
    spm_set = '{16'd1, 16'd65535, 16'd60, 16'd0, 16'd65535, 16'd1, 16'd0, 16'd60};
    mph_set[6] = RADIX_W'($urandom_range(65535, 2));
    spm_set[6] = RADIX_W'($urandom_range(65535, 2));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset radices of sixty.
    set_idling(0);
    send_item(FUNC_LOAD, 0, 0, 0);
    send_item(FUNC_LOAD, 1, 61, 3661);
    // Exact negative multiples stay at zero and borrow nothing.
    send_item(FUNC_LOAD, 5, -120, 0);
    send_item(FUNC_LOAD, 0, 0, -120);
    send_item(FUNC_ADD, 0, 0, 1);
    send_item(FUNC_SUB, 0, 0, 1);
    send_item(FUNC_SUB, 0, 0, 1);
    send_item(FUNC_ADD, -1, -1, -1);
    send_item(FUNC_SUB, -1, -1, -1);
    send_item(FUNC_HOLD, 32'sh1234_5678, -7, 99);
    // Saturation at both ends of the hours range.
    send_item(FUNC_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(FUNC_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(FUNC_HOLD, 0, 0, 0);
    send_item(FUNC_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_item(FUNC_SUB, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_item(FUNC_LOAD, 0, 0, 0);
    send_item(FUNC_SUB, 32'sh8000_0000, 0, 0);
    send_item(FUNC_LOAD, 32'sh7fff_ffff, 59, 59);
    send_item(FUNC_ADD, 0, 0, 1);
    send_item(FUNC_LOAD, 32'sh8000_0000, 0, 0);
    send_item(FUNC_SUB, 0, 0, 1);
    send_item(FUNC_LOAD, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_item(FUNC_ADD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    drain_results();

    // Random phases, each under its own radix pair and idling pattern.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CFG_MPH, mph_set[p]);
      write_cfg(CFG_SPM, spm_set[p]);
      set_idling(p % 4);
      repeat (RANDOM_PER_PHASE) send_random();
      drain_results();
    end

    // Any stray item the block still returns now lands with nothing pending.
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** mixed_radix_time_accumulator: PASSED **");
    end else begin
      $display("** mixed_radix_time_accumulator: FAILED **");
    end
    $finish;
  end

endmodule
